FILE: src/scblend_pkg.sv
`timescale 1ns / 1ps

package scblend_pkg;

  localparam int FRAME_W    = 10;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int MAX_FRAMES = 1024;

  localparam int IN_DATA_W  = ((FRAME_W + 2 * PIX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PIX_W + 7) / 8) * 8;

  localparam int Q_W        = 16;
  localparam int T_W        = Q_W + 1;
  localparam int REM_W      = FRAME_W + 1;
  localparam int DEN_W      = CFG_W + 1;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = Q_W / DIV_STAGES;

  localparam int SQ_W       = 2 * Q_W;
  localparam int CUBE_W     = 3 * Q_W;
  localparam int NUM_W      = CUBE_W + 2;
  localparam int DIFF_W     = PIX_W + 1;
  localparam int PROD_W     = DIFF_W + T_W + 1;
  localparam int SUM_W      = PROD_W + 1;

endpackage

FILE: src/smoothstep_crossfade_blender_top.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in_      in_tvalid/in_tready   in_tdata: frame_index, start_pixel, tail_pixel
// out_     out_tvalid/out_tready out_tdata: blended_pixel; out_tuser: was_blended
// cfg_     cfg_valid/cfg_ready   cfg_data: crossfade_frames
//
// One word is accepted per clock while the output is not stalled; each word passes
// through the input register, the four-stage divider (four quotient bits per stage),
// two multiplier stages, the weight stage, the blend multiply and the output
// register. Reset clears the crossfade length and all valid bits; the block accepts
// words in the first cycle after reset. A stall on the output freezes every stage.

module smoothstep_crossfade_blender_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // frame_index, start_pixel, tail_pixel, zero padding
  input  logic [scblend_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // blended_pixel
  output logic [scblend_pkg::OUT_DATA_W-1:0]    out_tdata,
  // was_blended
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scblend_pkg::CFG_W-1:0]         cfg_data
);
  import scblend_pkg::*;

  logic               en;
  logic [CFG_W-1:0]   cfg_r;
  logic [CFG_W-1:0]   len_eff;
  logic [DEN_W-1:0]   den;

  logic [FRAME_W-1:0] in_idx;
  logic [PIX_W-1:0]   in_start;
  logic [PIX_W-1:0]   in_tail;

  // Input stage
  logic               vld0_r;
  logic               blend0_r;
  logic [PIX_W-1:0]   start0_r, tail0_r;
  logic [REM_W-1:0]   rem0_r;

  // Divider stages
  logic               dvld_r   [DIV_STAGES];
  logic               dblend_r [DIV_STAGES];
  logic [PIX_W-1:0]   dstart_r [DIV_STAGES];
  logic [PIX_W-1:0]   dtail_r  [DIV_STAGES];
  logic [REM_W-1:0]   drem_r   [DIV_STAGES];
  logic [Q_W-1:0]     dq_r     [DIV_STAGES];
  logic [REM_W-1:0]   drem_nxt [DIV_STAGES];
  logic [Q_W-1:0]     dq_nxt   [DIV_STAGES];

  // Square stage
  logic               vld1_r, blend1_r;
  logic [PIX_W-1:0]   start1_r, tail1_r;
  logic [Q_W-1:0]     x1_r;
  logic [SQ_W-1:0]    xsq1_r;

  // Cube stage
  logic               vld2_r, blend2_r;
  logic [PIX_W-1:0]   start2_r, tail2_r;
  logic [SQ_W-1:0]    xsq2_r;
  logic [CUBE_W-1:0]  xcube2_r;

  // Weight stage
  logic               vld3_r, blend3_r;
  logic [PIX_W-1:0]   start3_r, tail3_r;
  logic [T_W-1:0]     t3_r;
  logic [NUM_W-1:0]   num_nxt;

  // Blend multiply stage
  logic               vld4_r, blend4_r;
  logic [PIX_W-1:0]   start4_r, tail4_r;
  logic signed [PROD_W-1:0] prod4_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [T_W:0]      tw;

  // Output register
  logic               out_vld_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic               out_blend_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [PIX_W:0]     v_nxt;
  logic [PIX_W-1:0]   pix_nxt;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  assign in_idx   = in_tdata[FRAME_W-1:0];
  assign in_start = in_tdata[FRAME_W +: PIX_W];
  assign in_tail  = in_tdata[FRAME_W + PIX_W +: PIX_W];

  assign len_eff = (cfg_r > CFG_W'(MAX_FRAMES)) ? CFG_W'(MAX_FRAMES) : cfg_r;
  assign den     = {len_eff, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  // Restoring division of (2i+1) * 2^16 by 2c, four quotient bits per stage.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W:0]   r2;
    logic [Q_W-1:0]   q;
    for (int k = 0; k < DIV_STAGES; k++) begin
      r = (k == 0) ? rem0_r : drem_r[(k == 0) ? 0 : k - 1];
      q = (k == 0) ? '0 : dq_r[(k == 0) ? 0 : k - 1];
      for (int b = 0; b < DIV_BITS; b++) begin
        r2 = {r, 1'b0};
        if (r2 >= den) begin
          r2 = r2 - den;
          q  = {q[Q_W-2:0], 1'b1};
        end else begin
          q  = {q[Q_W-2:0], 1'b0};
        end
        r = r2[REM_W-1:0];
      end
      drem_nxt[k] = r;
      dq_nxt[k]   = q;
    end
  end

  always_comb begin
    num_nxt = {2'b00, xsq2_r, {Q_W{1'b0}}}
            + {1'b0, xsq2_r, {(Q_W + 1){1'b0}}}
            - {1'b0, xcube2_r, 1'b0}
            + (NUM_W'(1) << (SQ_W - 1));
    diff     = $signed({1'b0, start3_r}) - $signed({1'b0, tail3_r});
    tw       = $signed({1'b0, t3_r});
    prod_nxt = PROD_W'(diff) * PROD_W'(tw);
    sum_nxt  = $signed({{(SUM_W - PIX_W - Q_W){1'b0}}, tail4_r, {Q_W{1'b0}}})
             + SUM_W'(prod4_r)
             + $signed(SUM_W'(1) << (Q_W - 1));
    v_nxt    = sum_nxt[Q_W +: PIX_W + 1];
    if (!blend4_r) begin
      pix_nxt = start4_r;
    end else if (v_nxt[PIX_W]) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = v_nxt[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r    <= 1'b0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dvld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld0_r    <= in_tvalid;
      dvld_r[0] <= vld0_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dvld_r[k] <= dvld_r[k-1];
      end
      vld1_r    <= dvld_r[DIV_STAGES-1];
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      vld4_r    <= vld3_r;
      out_vld_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blend0_r <= {1'b0, in_idx} < len_eff;
      start0_r <= in_start;
      tail0_r  <= in_tail;
      rem0_r   <= {in_idx, 1'b1};

      dblend_r[0] <= blend0_r;
      dstart_r[0] <= start0_r;
      dtail_r[0]  <= tail0_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dblend_r[k] <= dblend_r[k-1];
        dstart_r[k] <= dstart_r[k-1];
        dtail_r[k]  <= dtail_r[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        drem_r[k] <= drem_nxt[k];
        dq_r[k]   <= dq_nxt[k];
      end

      blend1_r <= dblend_r[DIV_STAGES-1];
      start1_r <= dstart_r[DIV_STAGES-1];
      tail1_r  <= dtail_r[DIV_STAGES-1];
      x1_r     <= dq_r[DIV_STAGES-1];
      xsq1_r   <= dq_r[DIV_STAGES-1] * dq_r[DIV_STAGES-1];

      blend2_r <= blend1_r;
      start2_r <= start1_r;
      tail2_r  <= tail1_r;
      xsq2_r   <= xsq1_r;
      xcube2_r <= xsq1_r * x1_r;

      blend3_r <= blend2_r;
      start3_r <= start2_r;
      tail3_r  <= tail2_r;
      t3_r     <= num_nxt[SQ_W +: T_W];

      blend4_r <= blend3_r;
      start4_r <= start3_r;
      tail4_r  <= tail3_r;
      prod4_r  <= prod_nxt;

      out_pix_r   <= pix_nxt;
      out_blend_r <= blend4_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_pix_r);
  assign out_tuser  = out_blend_r;

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld0_r)
    else $error("accepted word did not enter the first stage");

  a_weight_bound : assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r && blend3_r |-> t3_r <= T_W'(1 << Q_W))
    else $error("smoothstep weight above one");

  a_stage_advance : assert property (@(posedge clk) disable iff (!rst_n)
    en && vld4_r |=> out_vld_r)
    else $error("word lost between blend stage and output");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en && vld3_r |=> vld3_r && $stable(t3_r))
    else $error("weight stage changed during a stall");

endmodule
